>>> hdl/hpm_pkg.sv
package hpm_pkg;

  localparam int VOICES_DEF    = 4;
  localparam int PAT_W         = 32;
  localparam int LEN_W         = 6;
  localparam int INT_W         = 12;
  localparam int SHAKE_W       = 14;
  localparam int FLAG_W        = 4;
  localparam int IN_W          = 64;
  localparam int OUT_W         = 96;
  localparam int PATTERN_STEPS = 32;
  localparam int REPLACE_LIMIT = 9999;
  localparam int LOOP_FACTOR   = 10;
  localparam int THRESH_Q8     = 25;
  localparam int SHAKE_MAX     = 16383;
  localparam int TENTH_TOP     = 6;
  localparam int TENTH_MID     = 3;
  localparam int TENTH_LOW     = 1;
  localparam int TEN           = 10;
  localparam int SQ_W          = 2 * INT_W;
  localparam int RECIP10       = 838861;
  localparam int RECIP10_SH    = 23;

  localparam int F_DRIVE = 0;
  localparam int F_LOOP  = 1;
  localparam int F_PADA  = 2;
  localparam int F_PADB  = 3;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_START    = 2'd1,
    REQ_STOP_ONE = 2'd2,
    REQ_STOP_ALL = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VOICE,
    ST_VDIV,
    ST_BEST,
    ST_SQ,
    ST_SACC,
    ST_SDIV,
    ST_LVL,
    ST_LDIV,
    ST_DONE
  } state_t;

endpackage

>>> hdl/haptic_pattern_mixer_unit.sv
// Channel | Dir | Signals                    | Contents
// request | in  | s_tvalid s_tready s_tdata  | slot, pattern, length, intensity, flags
//         |     | s_tuser                    | request kind
// result  | out | m_tvalid m_tready m_tdata  | slot, shake, pad A and pad B reports
// A start or stop request goes straight to the last state, which loads its result.
// A tick visits each voice and, if a drive voice is active, the best, sum and level states
// before the next ready; voice and shake-term divisions use the shared 24-step divider.
// Reset is synchronous and frees all voices at once.
// A new request is taken while the previous result still waits on m_tready; a finished
// result waits in the last state until the output register is free.
module haptic_pattern_mixer_unit #(
  parameter int VOICES = hpm_pkg::VOICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // slot_index, pattern_bits, pattern_length, peak_intensity, flag_drive_shake,
  // flag_loop, flag_pad_a, flag_pad_b, zero fill
  input  logic [hpm_pkg::IN_W-1:0]  s_tdata,
  // req_type
  input  logic [1:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // assigned_slot, shake_valid, shake_level, pad_a_start, pad_a_bits,
  // pad_a_length, pad_b_start, pad_b_bits, pad_b_length, zero fill
  output logic [hpm_pkg::OUT_W-1:0] m_tdata
);

  localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SUMW = hpm_pkg::INT_W + VW + 1;
  localparam int LVW  = SUMW + 4;
  localparam int DW   = (hpm_pkg::SQ_W > LVW) ? hpm_pkg::SQ_W : LVW;
  localparam int PW   = hpm_pkg::PAT_W;
  localparam int LW   = hpm_pkg::LEN_W;
  localparam int IW   = hpm_pkg::INT_W;
  localparam int PRW  = LVW + 20;
  localparam int QW   = PRW - hpm_pkg::RECIP10_SH;

  logic [LW-1:0]              v_len [VOICES];
  logic [LW-1:0]              v_rem [VOICES];
  logic [PW-1:0]              v_pat [VOICES];
  logic [IW-1:0]              v_int [VOICES];
  logic [hpm_pkg::FLAG_W-1:0] v_flg [VOICES];
  logic [IW-1:0]              inten [VOICES];

  hpm_pkg::state_t state, state_next;
  logic [VW-1:0]   cur, cur_next;
  logic [PW-1:0]   merged, merged_next;
  logic [LW-1:0]   combined, combined_next;
  logic [PW-1:0]   pa_bits, pa_bits_next, pb_bits, pb_bits_next;
  logic [LW-1:0]   pa_len, pa_len_next, pb_len, pb_len_next;
  logic            pa_start, pa_start_next, pb_start, pb_start_next;
  logic [VW-1:0]   best, best_next;
  logic [IW-1:0]   bestval, bestval_next;
  logic            found, found_next;
  logic [SUMW-1:0] sum, sum_next;
  logic [hpm_pkg::SQ_W-1:0] sq;
  logic [1:0]      w_slot, w_slot_next;
  logic            w_sv, w_sv_next;
  logic [hpm_pkg::SHAKE_W-1:0] w_shake, w_shake_next;
  logic            out_load;

  logic            accept;
  hpm_pkg::req_t   req;
  logic [2:0]      in_slot;
  logic [PW-1:0]   in_pat;
  logic [LW-1:0]   in_len, len_sat;
  logic [IW-1:0]   in_int;
  logic [hpm_pkg::FLAG_W-1:0] in_flg;
  logic [VW-1:0]   start_idx;
  logic            free_seen;

  logic [LW-1:0]   vr, vl, off, vr_new;
  logic [PW-1:0]   vp, sh;
  logic [IW-1:0]   vi, lim;
  logic [hpm_pkg::FLAG_W-1:0] vf;
  logic            advance;
  logic [3:0]      tenths;
  logic [27:0]     sq10;
  logic [LVW-1:0]  lvnum;
  logic [PRW-1:0]  lprod;
  logic [QW-1:0]   lq;

  logic            div_start, div_done;
  logic [DW-1:0]   div_dividend, div_q;
  logic [IW-1:0]   div_divisor;

  hpm_div #(.DW(DW), .SW(IW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign s_tready = (state == hpm_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign req      = hpm_pkg::req_t'(s_tuser);
  assign in_slot  = s_tdata[2:0];
  assign in_pat   = s_tdata[34:3];
  assign in_len   = s_tdata[40:35];
  assign in_int   = s_tdata[52:41];
  assign in_flg   = s_tdata[56:53];
  assign len_sat  = (in_len > LW'(hpm_pkg::PATTERN_STEPS)) ? LW'(hpm_pkg::PATTERN_STEPS)
                                                             : in_len;

  always_comb begin
    start_idx = '0;
    free_seen = 1'b0;
    for (int i = 0; i < VOICES; i++) begin
      if (!free_seen) begin
        if (v_rem[i] == '0) begin
          start_idx = VW'(i);
          free_seen = 1'b1;
        end else if ((v_flg[i][hpm_pkg::F_LOOP]
                      ? 10'(v_len[i]) * 10'(hpm_pkg::LOOP_FACTOR) : 10'(v_rem[i]))
                     < 14'(hpm_pkg::REPLACE_LIMIT)) begin
          start_idx = VW'(i);
        end
      end
    end
  end

  assign vr     = v_rem[cur];
  assign vl     = v_len[cur];
  assign vp     = v_pat[cur];
  assign vi     = v_int[cur];
  assign vf     = v_flg[cur];
  assign off    = (vl >= vr) ? vl - vr : '0;
  assign sh     = off[5] ? '0 : vp << off[4:0];
  assign vr_new = ((vr == LW'(1)) && vf[hpm_pkg::F_LOOP]) ? vl : vr - LW'(1);
  assign lim    = found ? bestval : IW'(hpm_pkg::THRESH_Q8);
  assign tenths = (merged[PW-1] ? 4'(hpm_pkg::TENTH_TOP) : 4'd0)
                + (merged[PW-2] ? 4'(hpm_pkg::TENTH_MID) : 4'd0)
                + (merged[PW-3] ? 4'(hpm_pkg::TENTH_LOW) : 4'd0);
  assign sq10   = 28'(sq) * 28'(hpm_pkg::TEN);
  assign lprod  = PRW'(lvnum) * PRW'(hpm_pkg::RECIP10);
  assign lq     = lprod[PRW-1:hpm_pkg::RECIP10_SH];

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    merged_next   = merged;
    combined_next = combined;
    pa_bits_next  = pa_bits;
    pb_bits_next  = pb_bits;
    pa_len_next   = pa_len;
    pb_len_next   = pb_len;
    pa_start_next = pa_start;
    pb_start_next = pb_start;
    best_next     = best;
    bestval_next  = bestval;
    found_next    = found;
    sum_next      = sum;
    w_slot_next   = w_slot;
    w_sv_next     = w_sv;
    w_shake_next  = w_shake;
    out_load      = 1'b0;
    advance       = 1'b0;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;
    case (state)
      hpm_pkg::ST_IDLE: begin
        if (accept) begin
          merged_next   = '0;
          combined_next = '0;
          pa_bits_next  = '0;
          pb_bits_next  = '0;
          pa_len_next   = '0;
          pb_len_next   = '0;
          pa_start_next = 1'b0;
          pb_start_next = 1'b0;
          w_slot_next   = '0;
          w_sv_next     = 1'b0;
          w_shake_next  = '0;
          cur_next      = '0;
          found_next    = 1'b0;
          bestval_next  = '0;
          best_next     = '0;
          sum_next      = '0;
          if (req == hpm_pkg::REQ_TICK) begin
            state_next = hpm_pkg::ST_VOICE;
          end else begin
            if (req == hpm_pkg::REQ_START) begin
              w_slot_next = 2'(start_idx);
            end
            state_next = hpm_pkg::ST_DONE;
          end
        end
      end
      hpm_pkg::ST_VOICE: begin
        advance = 1'b1;
        if (vr != '0) begin
          if (vf[hpm_pkg::F_DRIVE]) begin
            merged_next = merged | sh;
            if (combined < vr) combined_next = vr;
            if (!vf[hpm_pkg::F_LOOP] && (vl != '0)) begin
              div_start    = 1'b1;
              div_dividend = DW'(18'(vi) * 18'(vr));
              div_divisor  = IW'(vl);
              advance      = 1'b0;
              state_next   = hpm_pkg::ST_VDIV;
            end
          end
          if (vf[hpm_pkg::F_PADA]) begin
            pa_bits_next = pa_bits | sh;
            if (pa_len < vr) pa_len_next = vr;
            if (off == '0) pa_start_next = 1'b1;
          end
          if (vf[hpm_pkg::F_PADB]) begin
            pb_bits_next = pb_bits | sh;
            if (pb_len < vr) pb_len_next = vr;
            if (off == '0) pb_start_next = 1'b1;
          end
        end
      end
      hpm_pkg::ST_VDIV: begin
        advance = div_done;
      end
      hpm_pkg::ST_BEST: begin
        if (inten[cur] > lim) begin
          bestval_next = inten[cur];
          best_next    = cur;
          found_next   = 1'b1;
        end
        if (cur == VW'(VOICES - 1)) begin
          cur_next   = '0;
          state_next = hpm_pkg::ST_SQ;
        end else begin
          cur_next = cur + VW'(1);
        end
      end
      hpm_pkg::ST_SQ: begin
        if (cur == best) begin
          sum_next = sum + SUMW'(inten[cur]);
          if (cur == VW'(VOICES - 1)) begin
            state_next = hpm_pkg::ST_LVL;
          end else begin
            cur_next = cur + VW'(1);
          end
        end else begin
          state_next = hpm_pkg::ST_SACC;
        end
      end
      hpm_pkg::ST_SACC: begin
        if (found) begin
          div_start    = 1'b1;
          div_dividend = DW'(sq);
          div_divisor  = bestval;
          state_next   = hpm_pkg::ST_SDIV;
        end else begin
          sum_next = sum + SUMW'(sq10[19:8]);
          if (cur == VW'(VOICES - 1)) begin
            state_next = hpm_pkg::ST_LVL;
          end else begin
            cur_next   = cur + VW'(1);
            state_next = hpm_pkg::ST_SQ;
          end
        end
      end
      hpm_pkg::ST_SDIV: begin
        if (div_done) begin
          sum_next = sum + SUMW'(div_q[IW-1:0]);
          if (cur == VW'(VOICES - 1)) begin
            state_next = hpm_pkg::ST_LVL;
          end else begin
            cur_next   = cur + VW'(1);
            state_next = hpm_pkg::ST_SQ;
          end
        end
      end
      hpm_pkg::ST_LVL: begin
        state_next = hpm_pkg::ST_LDIV;
      end
      hpm_pkg::ST_LDIV: begin
        // The division by ten is a multiplication by a scaled reciprocal.
        w_sv_next    = 1'b1;
        w_shake_next = (lq > QW'(hpm_pkg::SHAKE_MAX))
                       ? hpm_pkg::SHAKE_W'(hpm_pkg::SHAKE_MAX)
                       : lq[hpm_pkg::SHAKE_W-1:0];
        state_next   = hpm_pkg::ST_DONE;
      end
      hpm_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = hpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hpm_pkg::ST_IDLE;
      end
    endcase
    if (advance) begin
      if (cur == VW'(VOICES - 1)) begin
        cur_next   = '0;
        state_next = (combined_next == '0) ? hpm_pkg::ST_DONE : hpm_pkg::ST_BEST;
      end else begin
        cur_next   = cur + VW'(1);
        state_next = hpm_pkg::ST_VOICE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hpm_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < VOICES; i++) v_rem[i] <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept && (req == hpm_pkg::REQ_START)) begin
        v_rem[start_idx] <= len_sat;
      end else if (accept && (req == hpm_pkg::REQ_STOP_ONE)) begin
        if (32'(in_slot) < VOICES) v_rem[VW'(in_slot)] <= '0;
      end else if (accept && (req == hpm_pkg::REQ_STOP_ALL)) begin
        for (int i = 0; i < VOICES; i++) v_rem[i] <= '0;
      end else if ((state == hpm_pkg::ST_VOICE) && (vr != '0)) begin
        v_rem[cur] <= vr_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    merged   <= merged_next;
    combined <= combined_next;
    pa_bits  <= pa_bits_next;
    pb_bits  <= pb_bits_next;
    pa_len   <= pa_len_next;
    pb_len   <= pb_len_next;
    pa_start <= pa_start_next;
    pb_start <= pb_start_next;
    best     <= best_next;
    bestval  <= bestval_next;
    found    <= found_next;
    sum      <= sum_next;
    w_slot   <= w_slot_next;
    w_sv     <= w_sv_next;
    w_shake  <= w_shake_next;
    if (state == hpm_pkg::ST_SQ) begin
      sq <= hpm_pkg::SQ_W'(inten[cur]) * hpm_pkg::SQ_W'(inten[cur]);
    end
    if (state == hpm_pkg::ST_LVL) begin
      lvnum <= LVW'(sum) * LVW'(tenths);
    end
    if (accept && (req == hpm_pkg::REQ_START)) begin
      v_len[start_idx] <= len_sat;
      v_pat[start_idx] <= in_pat;
      v_int[start_idx] <= in_int;
      v_flg[start_idx] <= in_flg;
    end
    if (state == hpm_pkg::ST_VOICE) begin
      inten[cur] <= ((vr != '0) && vf[hpm_pkg::F_DRIVE]) ? vi : '0;
    end else if ((state == hpm_pkg::ST_VDIV) && div_done) begin
      inten[cur] <= div_q[IW-1:0];
    end
    if (out_load) begin
      m_tdata <= {1'b0, pb_len, pb_bits, pb_start, pa_len, pa_bits, pa_start,
                  w_shake, w_sv, w_slot};
    end
  end

endmodule

>>> hdl/hpm_div.sv
module hpm_div #(
  parameter int DW = 24,
  parameter int SW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SW-1:0] rem;
  logic [SW-1:0] dsr;
  logic [DW-1:0] quo;
  logic [SW:0]   trial;
  logic          take;

  assign trial    = {rem, quo[DW-1]};
  assign take     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= take ? SW'(trial - {1'b0, dsr}) : trial[SW-1:0];
      quo <= {quo[DW-2:0], take};
    end
  end

endmodule

>>> hdl/hpm_checker.sv
module hpm_sva (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [hpm_pkg::OUT_W-1:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed.");

  a_shake_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[16:3] == 14'd0)
    else $error("Shake level set without shake valid.");

  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != 2'd0) |-> !m_tdata[2] && !m_tdata[17] && !m_tdata[56])
    else $error("Start result carries tick fields.");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:50] <= 6'd32 && m_tdata[94:89] <= 6'd32)
    else $error("Pad length beyond pattern steps.");

endmodule

bind haptic_pattern_mixer_unit hpm_sva u_hpm_sva (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/sv/hpm_checker.sv
module hpm_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [hpm_pkg::IN_W-1:0]  s_tdata,
  input  logic [1:0]                s_tuser,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [hpm_pkg::OUT_W-1:0] m_tdata,
  output int                        fail_count,
  output int                        pending
);

  logic [hpm_pkg::LEN_W-1:0]  v_len [hpm_pkg::VOICES_DEF];
  logic [hpm_pkg::LEN_W-1:0]  v_rem [hpm_pkg::VOICES_DEF];
  logic [hpm_pkg::PAT_W-1:0]  v_pat [hpm_pkg::VOICES_DEF];
  logic [hpm_pkg::INT_W-1:0]  v_int [hpm_pkg::VOICES_DEF];
  logic [hpm_pkg::FLAG_W-1:0] v_flg [hpm_pkg::VOICES_DEF];
  logic [hpm_pkg::OUT_W-1:0]  expected_reports [$];

  function automatic logic [hpm_pkg::OUT_W-1:0] mix_request(input hpm_pkg::req_t kind,
                                                            input logic [hpm_pkg::IN_W-1:0] d);
    logic [2:0] slot;
    logic [hpm_pkg::PAT_W-1:0] pat;
    logic [hpm_pkg::LEN_W-1:0] len_in;
    logic [31:0] len, rem, off, left, sh, merged, combined, bestval, tenths;
    logic [31:0] inten [hpm_pkg::VOICES_DEF];
    logic [31:0] pbits [2];
    logic [31:0] plen [2];
    logic [1:0] pstart;
    logic [63:0] sum, lvl, t;
    logic [hpm_pkg::OUT_W-1:0] r;
    int idx, best;
    bit found;
    slot = d[2:0];
    pat = d[34:3];
    len_in = d[40:35];
    r = '0;
    case (kind)
      hpm_pkg::REQ_START: begin
        idx = 0;
        for (int i = 0; i < hpm_pkg::VOICES_DEF; i++) begin
          if (v_rem[i] == '0) begin
            idx = i;
            break;
          end
          left = v_flg[i][hpm_pkg::F_LOOP] ? 32'(v_len[i]) * 32'(hpm_pkg::LOOP_FACTOR)
                                           : 32'(v_rem[i]);
          if (left < 32'(hpm_pkg::REPLACE_LIMIT)) idx = i;
        end
        len = (32'(len_in) > 32'(hpm_pkg::PATTERN_STEPS)) ? 32'(hpm_pkg::PATTERN_STEPS)
                                                          : 32'(len_in);
        v_len[idx] = len[hpm_pkg::LEN_W-1:0];
        v_rem[idx] = len[hpm_pkg::LEN_W-1:0];
        v_pat[idx] = pat;
        v_int[idx] = d[52:41];
        v_flg[idx] = d[56:53];
        r[1:0] = 2'(idx);
      end
      hpm_pkg::REQ_STOP_ONE: begin
        if (32'(slot) < 32'(hpm_pkg::VOICES_DEF)) v_rem[slot[1:0]] = '0;
      end
      hpm_pkg::REQ_STOP_ALL: begin
        for (int i = 0; i < hpm_pkg::VOICES_DEF; i++) v_rem[i] = '0;
      end
      default: begin
        merged = 0;
        combined = 0;
        pbits = '{0, 0};
        plen = '{0, 0};
        pstart = 0;
        for (int i = 0; i < hpm_pkg::VOICES_DEF; i++) begin
          inten[i] = 0;
          rem = 32'(v_rem[i]);
          len = 32'(v_len[i]);
          if (rem == 0) continue;
          off = (len >= rem) ? len - rem : 0;
          sh = (off >= 32) ? 0 : v_pat[i] << off;
          if (v_flg[i][hpm_pkg::F_DRIVE]) begin
            merged |= sh;
            if (v_flg[i][hpm_pkg::F_LOOP] || len == 0) inten[i] = 32'(v_int[i]);
            else inten[i] = 32'(v_int[i]) * rem / len;
            if (combined < rem) combined = rem;
          end
          for (int p = 0; p < 2; p++) begin
            if (v_flg[i][hpm_pkg::F_PADA + p]) begin
              pbits[p] |= sh;
              if (plen[p] < rem) plen[p] = rem;
              if (off == 0) pstart[p] = 1'b1;
            end
          end
          rem = rem - 1;
          if (rem == 0 && v_flg[i][hpm_pkg::F_LOOP]) rem = len;
          v_rem[i] = rem[hpm_pkg::LEN_W-1:0];
        end
        if (combined != 0) begin
          best = 0;
          bestval = 0;
          found = 0;
          sum = 0;
          tenths = 0;
          for (int i = 0; i < hpm_pkg::VOICES_DEF; i++) begin
            if (inten[i] > (found ? bestval : 32'(hpm_pkg::THRESH_Q8))) begin
              bestval = inten[i];
              best = i;
              found = 1;
            end
          end
          for (int i = 0; i < hpm_pkg::VOICES_DEF; i++) begin
            t = 64'(inten[i]);
            if (i == best) sum += t;
            else if (found) sum += t * t / 64'(bestval);
            else sum += t * t * 64'(hpm_pkg::TEN) / 64'd256;
          end
          if (merged[31]) tenths += 32'(hpm_pkg::TENTH_TOP);
          if (merged[30]) tenths += 32'(hpm_pkg::TENTH_MID);
          if (merged[29]) tenths += 32'(hpm_pkg::TENTH_LOW);
          lvl = sum * 64'(tenths) / 64'(hpm_pkg::TEN);
          if (lvl > 64'(hpm_pkg::SHAKE_MAX)) lvl = 64'(hpm_pkg::SHAKE_MAX);
          r[2] = 1'b1;
          r[16:3] = lvl[13:0];
        end
        r[17] = pstart[0];
        r[49:18] = pbits[0];
        r[55:50] = plen[0][5:0];
        r[56] = pstart[1];
        r[88:57] = pbits[1];
        r[94:89] = plen[1][5:0];
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    logic [hpm_pkg::OUT_W-1:0] want;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
      expected_reports.delete();
      for (int i = 0; i < hpm_pkg::VOICES_DEF; i++) begin
        v_rem[i] = '0;
        v_len[i] = '0;
        v_pat[i] = '0;
        v_int[i] = '0;
        v_flg[i] = '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_reports.pop_front();
          if (want !== m_tdata) begin
            if (fail_count < 10) $display("mismatch: expected %h actual %h", want, m_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_reports.push_back(mix_request(hpm_pkg::req_t'(s_tuser), s_tdata));
      end
      pending <= expected_reports.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [hpm_pkg::IN_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [hpm_pkg::OUT_W-1:0] m_tdata;
  int fail_count;
  int pending;
  int cycles = 0;
  bit calm;

  haptic_pattern_mixer_unit i_dut (.*);

  hpm_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready = 0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      m_tready = 1;
    end
  end

  task automatic send_request(input hpm_pkg::req_t kind, input logic [2:0] slot,
                              input logic [31:0] pat, input logic [5:0] len,
                              input logic [11:0] peak, input logic [3:0] flags);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {7'b0, flags, peak, len, pat, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      send_request(hpm_pkg::REQ_TICK, 3'($urandom), $urandom, 6'($urandom), 12'($urandom),
                   4'($urandom));
    end else if (roll < 85) begin
      send_request(hpm_pkg::REQ_START, 3'($urandom), $urandom,
                   ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 12)),
                   12'($urandom), 4'($urandom));
    end else if (roll < 97) begin
      send_request(hpm_pkg::REQ_STOP_ONE, 3'($urandom), $urandom, 6'($urandom),
                   12'($urandom), 4'($urandom));
    end else begin
      send_request(hpm_pkg::REQ_STOP_ALL, 3'($urandom), $urandom, 6'($urandom),
                   12'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    calm = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = hpm_pkg::REQ_TICK;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_request(hpm_pkg::REQ_TICK, 3'd0, 32'h0, 6'd0, 12'h0, 4'h0);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'hFFFF_FFFF, 6'd32, 12'hFFF, 4'hF);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'hA000_0001, 6'd63, 12'h0, 4'h5);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'h0, 6'd0, 12'h19, 4'h1);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'h8000_0000, 6'd3, 12'h1A, 4'h9);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'hC000_0000, 6'd2, 12'h80, 4'h3);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'h2000_0000, 6'd5, 12'h20, 4'h7);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'h6000_0000, 6'd33, 12'h100, 4'hD);
    repeat (4) send_request(hpm_pkg::REQ_TICK, 3'd7, 32'h0, 6'd0, 12'h0, 4'h0);
    send_request(hpm_pkg::REQ_STOP_ONE, 3'd7, 32'h0, 6'd0, 12'h0, 4'h0);
    send_request(hpm_pkg::REQ_STOP_ONE, 3'd4, 32'h0, 6'd0, 12'h0, 4'h0);
    send_request(hpm_pkg::REQ_STOP_ONE, 3'd1, 32'h0, 6'd0, 12'h0, 4'h0);
    send_request(hpm_pkg::REQ_TICK, 3'd0, 32'h0, 6'd0, 12'h0, 4'h0);
    send_request(hpm_pkg::REQ_STOP_ALL, 3'd0, 32'h0, 6'd0, 12'h0, 4'h0);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'hE000_0000, 6'd1, 12'h10, 4'h1);
    send_request(hpm_pkg::REQ_START, 3'd0, 32'hE000_0000, 6'd1, 12'h5, 4'h1);
    send_request(hpm_pkg::REQ_TICK, 3'd0, 32'h0, 6'd0, 12'h0, 4'h0);
    send_request(hpm_pkg::REQ_TICK, 3'd0, 32'h0, 6'd0, 12'h0, 4'h0);
    repeat (750) random_request();
    calm = 1;
    repeat (100) random_request();
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
